@@ rtl/emc_pkg.sv @@
// Shared codes, widths, and write-command and result structs of the message classifier.
`default_nettype none

package emc_pkg;

	localparam int OP_W   = 2;
	localparam int KEY_W  = 32;
	localparam int HID_W  = 8;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
	localparam logic [OP_W-1:0] OP_REGISTER   = 2'd1;
	localparam logic [OP_W-1:0] OP_DEREGISTER = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EXISTS  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd3;

	localparam logic [KEY_W-1:0] FULL_MASK = 32'hFFFF_FFFF;

	// table write command: en with set stores an entry, en without set frees it
	typedef struct packed {
		logic en;
		logic set;
	} wr_cmd_t;

	typedef struct packed {
		logic hit;
		logic free;
	} ex_res_t;

	typedef struct packed {
		logic best;
		logic exists;
		logic del_hit;
		logic free;
	} mk_res_t;

endpackage

`default_nettype wire

@@ rtl/emc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module emc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/emc_exact_tbl.sv @@
// Exact table: entry RAM, valid bits and a one-entry-per-cycle scan.
`default_nettype none

module emc_exact_tbl import emc_pkg::*; #(
	parameter int ENTRIES = 32,
	parameter int HB = 8,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [HB-1:0]    handler,
	input  wire wr_cmd_t          wr,
	input  wire logic [AW-1:0]    wr_idx,
	output logic                  busy,
	output ex_res_t               res,
	output logic      [AW-1:0]    hit_idx,
	output logic      [HB-1:0]    hit_handler,
	output logic      [AW-1:0]    free_idx
);

	localparam int DW = KEY_W + HB;

	logic [ENTRIES-1:0] valid_q;
	logic               iss_q;
	logic [AW-1:0]      addr_q;
	logic               rd_s1;
	logic [AW-1:0]      idx_s1;
	logic               vld_s1;
	logic [DW-1:0]      rdata;
	logic [KEY_W-1:0]   rd_type;
	logic [HB-1:0]      rd_hdl;
	logic               hit_q;
	logic               free_q;

	emc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (wr.en && wr.set),
		.waddr (wr_idx),
		.wdata ({handler, key}),
		.re    (iss_q),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign rd_type = rdata[KEY_W-1:0];
	assign rd_hdl  = rdata[KEY_W +: HB];
	assign busy    = iss_q || rd_s1;
	assign res     = '{hit: hit_q, free: free_q};

	// issue stage: walk the addresses, sample the valid bit alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q  <= 1'b0;
			addr_q <= '0;
			rd_s1  <= 1'b0;
		end else begin
			rd_s1 <= iss_q;
			if (start) begin
				iss_q  <= 1'b1;
				addr_q <= '0;
			end else if (iss_q) begin
				if (addr_q == AW'(ENTRIES - 1)) begin
					iss_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		vld_s1 <= valid_q[addr_q];
	end

	// compare stage: keep the first hit and the lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_s1) begin
			if (vld_s1 && rd_type == key && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!vld_s1 && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1 && vld_s1 && rd_type == key && !hit_q) begin
			hit_idx     <= idx_s1;
			hit_handler <= rd_hdl;
		end
		if (rd_s1 && !vld_s1 && !free_q) begin
			free_idx <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr_idx] <= wr.set;
		end
	end

endmodule

`default_nettype wire

@@ rtl/emc_masked_tbl.sv @@
// Masked table: pattern/mask RAM, valid bits and a scan for best match, duplicate, deregister match and free slot.
`default_nettype none

module emc_masked_tbl import emc_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int HB = 8,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [KEY_W-1:0] mask,
	input  wire logic [HB-1:0]    handler,
	input  wire wr_cmd_t          wr,
	input  wire logic [AW-1:0]    wr_idx,
	output logic                  busy,
	output mk_res_t               res,
	output logic      [HB-1:0]    best_handler,
	output logic      [AW-1:0]    del_idx,
	output logic      [AW-1:0]    free_idx
);

	localparam int DW = 2 * KEY_W + HB;

	logic [ENTRIES-1:0] valid_q;
	logic               iss_q;
	logic [AW-1:0]      addr_q;
	logic               rd_s1;
	logic [AW-1:0]      idx_s1;
	logic               vld_s1;
	logic [DW-1:0]      rdata;
	logic [KEY_W-1:0]   rd_pat;
	logic [KEY_W-1:0]   rd_mask;
	logic [HB-1:0]      rd_hdl;
	logic               best_q;
	logic [KEY_W-1:0]   best_mask_q;
	logic [KEY_W-1:0]   best_pat_q;
	logic               exists_q;
	logic               del_q;
	logic               free_q;
	logic               match;
	logic               better;
	logic               take_best;
	logic               take_del;
	logic               take_free;

	emc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (wr.en && wr.set),
		.waddr (wr_idx),
		.wdata ({handler, mask, key}),
		.re    (iss_q),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign rd_pat  = rdata[KEY_W-1:0];
	assign rd_mask = rdata[KEY_W +: KEY_W];
	assign rd_hdl  = rdata[2*KEY_W +: HB];
	assign busy    = iss_q || rd_s1;
	assign res     = '{best: best_q, exists: exists_q, del_hit: del_q, free: free_q};

	// greater mask wins, then greater stored type
	assign match  = vld_s1 && ((key & rd_mask) == rd_pat);
	assign better = !best_q || (rd_mask > best_mask_q) ||
	                ((rd_mask == best_mask_q) && (rd_pat > best_pat_q));
	assign take_best = rd_s1 && match && better;
	assign take_del  = rd_s1 && vld_s1 && (rd_pat == (key & mask)) && !del_q;
	assign take_free = rd_s1 && !vld_s1 && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q  <= 1'b0;
			addr_q <= '0;
			rd_s1  <= 1'b0;
		end else begin
			rd_s1 <= iss_q;
			if (start) begin
				iss_q  <= 1'b1;
				addr_q <= '0;
			end else if (iss_q) begin
				if (addr_q == AW'(ENTRIES - 1)) begin
					iss_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		vld_s1 <= valid_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= 1'b0;
			exists_q <= 1'b0;
			del_q    <= 1'b0;
			free_q   <= 1'b0;
		end else if (start) begin
			best_q   <= 1'b0;
			exists_q <= 1'b0;
			del_q    <= 1'b0;
			free_q   <= 1'b0;
		end else if (rd_s1) begin
			if (take_best) begin
				best_q <= 1'b1;
			end
			if (vld_s1 && rd_pat == key) begin
				exists_q <= 1'b1;
			end
			if (take_del) begin
				del_q <= 1'b1;
			end
			if (take_free) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_best) begin
			best_mask_q  <= rd_mask;
			best_pat_q   <= rd_pat;
			best_handler <= rd_hdl;
		end
		if (take_del) begin
			del_idx <= idx_s1;
		end
		if (take_free) begin
			free_idx <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr_idx] <= wr.set;
		end
	end

endmodule

`default_nettype wire

@@ rtl/exact_and_masked_message_classifier_top.sv @@
// Top level: item capture, scan sequencing, result decision and output register.
// Both tables are scanned side by side, one entry a cycle, for each accepted item. A new item
// is accepted only in idle, after the previous decision has gone into the output register.
// Reset: arst_n clears all valid bits, the sequencer and the output valid at once; no sweep.
`default_nettype none

module exact_and_masked_message_classifier_top import emc_pkg::*; #(
	parameter int EXACT_ENTRIES  = 32,
	parameter int MASKED_ENTRIES = 16,
	parameter int HANDLER_BITS   = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[1:0], key_value[33:2], match_mask[65:34], handler_id[73:66], zero pad
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[1:0], found_handler[9:2], hit_was_exact[10], zero pad
	output logic      [15:0] m_tdata
);

	localparam int EAW = (EXACT_ENTRIES > 1) ? $clog2(EXACT_ENTRIES) : 1;
	localparam int MAW = (MASKED_ENTRIES > 1) ? $clog2(MASKED_ENTRIES) : 1;
	// bits of handler_id that survive into the tables
	localparam int HC  = (HANDLER_BITS < HID_W) ? HANDLER_BITS : HID_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0]              state_q;
	logic [OP_W-1:0]         op_q;
	logic [KEY_W-1:0]        key_q;
	logic [KEY_W-1:0]        mask_q;
	logic [HID_W-1:0]        hid_q;
	logic [HANDLER_BITS-1:0] hcut;
	logic                    accept;
	logic                    dec_go;
	logic                    is_full;

	logic                    ex_busy;
	ex_res_t                 ex_res;
	logic [EAW-1:0]          ex_hit_idx;
	logic [HANDLER_BITS-1:0] ex_hit_hdl;
	logic [EAW-1:0]          ex_free_idx;
	wr_cmd_t                 ex_wr;
	logic [EAW-1:0]          ex_wr_idx;

	logic                    mk_busy;
	mk_res_t                 mk_res;
	logic [HANDLER_BITS-1:0] mk_best_hdl;
	logic [MAW-1:0]          mk_del_idx;
	logic [MAW-1:0]          mk_free_idx;
	wr_cmd_t                 mk_wr;
	logic [MAW-1:0]          mk_wr_idx;

	logic [STAT_W-1:0]       dec_status;
	logic [HID_W-1:0]        dec_hdl;
	logic                    dec_exact;

	logic                    out_vld_q;
	logic [STAT_W-1:0]       status_q;
	logic [HID_W-1:0]        found_q;
	logic                    exact_q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	// a decision leaves only when the output register is free or draining
	assign dec_go   = (state_q == ST_DECIDE) && (!out_vld_q || m_tready);
	assign is_full  = (mask_q == FULL_MASK);
	assign hcut     = HANDLER_BITS'(hid_q[HC-1:0]);

	// hold the item for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tdata[1:0];
			key_q  <= s_tdata[33:2];
			mask_q <= s_tdata[65:34];
			hid_q  <= s_tdata[73:66];
		end
	end

	emc_exact_tbl #(.ENTRIES(EXACT_ENTRIES), .HB(HANDLER_BITS)) u_exact (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.key         (key_q),
		.handler     (hcut),
		.wr          (ex_wr),
		.wr_idx      (ex_wr_idx),
		.busy        (ex_busy),
		.res         (ex_res),
		.hit_idx     (ex_hit_idx),
		.hit_handler (ex_hit_hdl),
		.free_idx    (ex_free_idx)
	);

	emc_masked_tbl #(.ENTRIES(MASKED_ENTRIES), .HB(HANDLER_BITS)) u_masked (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept),
		.key          (key_q),
		.mask         (mask_q),
		.handler      (hcut),
		.wr           (mk_wr),
		.wr_idx       (mk_wr_idx),
		.busy         (mk_busy),
		.res          (mk_res),
		.best_handler (mk_best_hdl),
		.del_idx      (mk_del_idx),
		.free_idx     (mk_free_idx)
	);

	// Both units compare once start has passed iss_q and rd_s1, with key_q already stable;
	// key_q then holds until the next item is accepted, past the write-back.

	// Decision: exact hit first, then best masked match; register and deregister
	// write back into the table that the mask selects.
	always_comb begin
		dec_status = STAT_NOMATCH;
		dec_hdl    = '0;
		dec_exact  = 1'b0;
		ex_wr      = '{en: 1'b0, set: 1'b0};
		mk_wr      = '{en: 1'b0, set: 1'b0};
		ex_wr_idx  = ex_hit_idx;
		mk_wr_idx  = mk_del_idx;
		case (op_q)
			OP_LOOKUP: begin
				if (ex_res.hit) begin
					dec_status = STAT_OK;
					dec_hdl    = HID_W'(ex_hit_hdl);
					dec_exact  = 1'b1;
				end else if (mk_res.best) begin
					dec_status = STAT_OK;
					dec_hdl    = HID_W'(mk_best_hdl);
				end
			end
			OP_REGISTER: begin
				if (is_full) begin
					if (ex_res.hit) begin
						dec_status = STAT_EXISTS;
					end else if (ex_res.free) begin
						dec_status = STAT_OK;
						ex_wr      = '{en: dec_go, set: 1'b1};
						ex_wr_idx  = ex_free_idx;
					end else begin
						dec_status = STAT_FULL;
					end
				end else begin
					if (mk_res.exists) begin
						dec_status = STAT_EXISTS;
					end else if (mk_res.free) begin
						dec_status = STAT_OK;
						mk_wr      = '{en: dec_go, set: 1'b1};
						mk_wr_idx  = mk_free_idx;
					end else begin
						dec_status = STAT_FULL;
					end
				end
			end
			OP_DEREGISTER: begin
				dec_status = STAT_OK;
				if (is_full && ex_res.hit) begin
					ex_wr = '{en: dec_go, set: 1'b0};
				end else if (!is_full && mk_res.del_hit) begin
					mk_wr = '{en: dec_go, set: 1'b0};
				end
			end
			default: begin
				dec_status = STAT_NOMATCH;
			end
		endcase
	end

	// sequencer: idle -> scan both tables -> decide and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!ex_busy && !mk_busy) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (dec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: load on decision, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (dec_go) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_go) begin
			status_q <= dec_status;
			found_q  <= dec_hdl;
			exact_q  <= dec_exact;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'b0, exact_q, found_q, status_q};

	a_start_scans: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (ex_busy && mk_busy))
		else $error("scan did not start after an accepted item");

	a_decide_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dec_go |-> (!ex_busy && !mk_busy))
		else $error("decision taken while a table scan is running");

	a_one_table_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(ex_wr.en && mk_wr.en))
		else $error("both tables written for one item");

	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DECIDE))
		else $error("result raised without a decision");

endmodule

`default_nettype wire

@@ bench/exact_and_masked_message_classifier_top_test.sv @@
// Self-checking bench for the exact and masked message classifier.
module exact_and_masked_message_classifier_top_test;
	import emc_pkg::*;

	localparam int EXACT_DEPTH  = 32;
	localparam int MASKED_DEPTH = 16;
	localparam int KEY_POOL     = 40;
	localparam int MASK_POOL    = 8;
	localparam int EPOCH_LEN    = 110;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 60;
	localparam int REPORT_LIMIT = 10;

	// opcode with no meaning: the block must answer no-match and touch nothing
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	typedef enum {FILL_EPOCH, MIXED_EPOCH, DRAIN_EPOCH} epoch_e;

	// one expected answer, tagged with the item that caused it for reporting
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		logic [STAT_W-1:0] status;
		logic [HID_W-1:0]  handler;
		logic              exact;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	int send_idle_pct  = 19;
	int recv_stall_pct = 54;
	int error_count    = 0;
	int cycle_count    = 0;

	// shadow copy of both tables
	logic [KEY_W-1:0] ex_key [EXACT_DEPTH];
	logic [HID_W-1:0] ex_hid [EXACT_DEPTH];
	logic             ex_used[EXACT_DEPTH];
	logic [KEY_W-1:0] mk_pat [MASKED_DEPTH];
	logic [KEY_W-1:0] mk_msk [MASKED_DEPTH];
	logic [HID_W-1:0] mk_hid [MASKED_DEPTH];
	logic             mk_used[MASKED_DEPTH];

	logic [KEY_W-1:0] key_pool [KEY_POOL];
	logic [KEY_W-1:0] mask_pool[MASK_POOL];

	outcome_t awaited_outcomes[$];
	outcome_t head_outcome;

	exact_and_masked_message_classifier_top #(
		.EXACT_ENTRIES (EXACT_DEPTH),
		.MASKED_ENTRIES(MASKED_DEPTH),
		.HANDLER_BITS  (HID_W)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// guard against a hung block
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stall the result side at random, per cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic int exact_index(input logic [KEY_W-1:0] key);
		for (int i = 0; i < EXACT_DEPTH; i++)
			if (ex_used[i] && ex_key[i] == key)
				return i;
		return -1;
	endfunction

	// masked entries are identified by their stored type alone, whatever the mask
	function automatic int masked_index(input logic [KEY_W-1:0] pattern);
		for (int i = 0; i < MASKED_DEPTH; i++)
			if (mk_used[i] && mk_pat[i] == pattern)
				return i;
		return -1;
	endfunction

	function automatic int pick_live_exact();
		int start;
		start = $urandom_range(EXACT_DEPTH - 1);
		for (int k = 0; k < EXACT_DEPTH; k++)
			if (ex_used[(start + k) % EXACT_DEPTH])
				return (start + k) % EXACT_DEPTH;
		return -1;
	endfunction

	function automatic int pick_live_masked();
		int start;
		start = $urandom_range(MASKED_DEPTH - 1);
		for (int k = 0; k < MASKED_DEPTH; k++)
			if (mk_used[(start + k) % MASKED_DEPTH])
				return (start + k) % MASKED_DEPTH;
		return -1;
	endfunction

	// Apply one item to the shadow tables and return the answer the block owes.
	function automatic outcome_t classify_item(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] msk,
			input logic [HID_W-1:0] hid);
		outcome_t o;
		int idx;
		int best;
		o.op      = op;
		o.key     = key;
		o.status  = STAT_NOMATCH;
		o.handler = '0;
		o.exact   = 1'b0;
		case (op)
			OP_LOOKUP: begin
				idx = exact_index(key);
				if (idx >= 0) begin
					o.status  = STAT_OK;
					o.handler = ex_hid[idx];
					o.exact   = 1'b1;
				end else begin
					// greater mask wins, then the greater stored type
					best = -1;
					for (int j = 0; j < MASKED_DEPTH; j++) begin
						if (!mk_used[j] || (key & mk_msk[j]) != mk_pat[j])
							continue;
						if (best < 0 || mk_msk[j] > mk_msk[best] ||
								(mk_msk[j] == mk_msk[best] && mk_pat[j] > mk_pat[best]))
							best = j;
					end
					if (best >= 0) begin
						o.status  = STAT_OK;
						o.handler = mk_hid[best];
					end
				end
			end
			OP_REGISTER: begin
				idx = -1;
				if (msk == FULL_MASK) begin
					if (exact_index(key) >= 0) begin
						o.status = STAT_EXISTS;
					end else begin
						for (int i = EXACT_DEPTH - 1; i >= 0; i--)
							if (!ex_used[i])
								idx = i;
						if (idx < 0) begin
							o.status = STAT_FULL;
						end else begin
							ex_key[idx]  = key;
							ex_hid[idx]  = hid;
							ex_used[idx] = 1'b1;
							o.status     = STAT_OK;
						end
					end
				end else begin
					if (masked_index(key) >= 0) begin
						o.status = STAT_EXISTS;
					end else begin
						for (int i = MASKED_DEPTH - 1; i >= 0; i--)
							if (!mk_used[i])
								idx = i;
						if (idx < 0) begin
							o.status = STAT_FULL;
						end else begin
							// the type is kept as given, stray bits and all
							mk_pat[idx]  = key;
							mk_msk[idx]  = msk;
							mk_hid[idx]  = hid;
							mk_used[idx] = 1'b1;
							o.status     = STAT_OK;
						end
					end
				end
			end
			OP_DEREGISTER: begin
				if (msk == FULL_MASK) begin
					idx = exact_index(key);
					if (idx >= 0)
						ex_used[idx] = 1'b0;
				end else begin
					idx = masked_index(key & msk);
					if (idx >= 0)
						mk_used[idx] = 1'b0;
				end
				o.status = STAT_OK;
			end
			default: ;
		endcase
		return o;
	endfunction

	// Offer one item, hold it until taken, and book its answer at the accepting edge.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [KEY_W-1:0] msk, input logic [HID_W-1:0] hid);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = {6'd0, hid, msk, key, op};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		awaited_outcomes.push_back(classify_item(op, key, msk, hid));
		@(negedge clk);
	endtask

	// Compare each answer with the oldest one booked.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_outcomes.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("unexpected result %h with no item outstanding", m_tdata);
			end else begin
				head_outcome = awaited_outcomes.pop_front();
				if (m_tdata[1:0] !== head_outcome.status ||
						m_tdata[9:2] !== head_outcome.handler ||
						m_tdata[10] !== head_outcome.exact) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("mismatch op %0d key %h: expected status %0d handler %h exact %0d, got status %0d handler %h exact %0d",
							head_outcome.op, head_outcome.key, head_outcome.status,
							head_outcome.handler, head_outcome.exact,
							m_tdata[1:0], m_tdata[9:2], m_tdata[10]);
				end
			end
		end
	end

	// Exact table: extremes of the type, duplicate, hit, removal and a removal of nothing.
	task automatic test_exact_table();
		send_item(OP_LOOKUP,     32'h0000_0000, 32'h0000_0000, 8'h00);
		send_item(OP_REGISTER,   32'hFFFF_FFFF, FULL_MASK,     8'hFF);
		send_item(OP_REGISTER,   32'h0000_0000, FULL_MASK,     8'h00);
		send_item(OP_REGISTER,   32'hFFFF_FFFF, FULL_MASK,     8'h12);
		send_item(OP_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000, 8'hFF);
		send_item(OP_LOOKUP,     32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
		send_item(OP_DEREGISTER, 32'hFFFF_FFFF, FULL_MASK,     8'h00);
		send_item(OP_DEREGISTER, 32'hFFFF_FFFF, FULL_MASK,     8'hFF);
		send_item(OP_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
	endtask

	// Masked table: greater mask wins, same type under another mask is refused,
	// a type with bits outside its mask never matches.
	task automatic test_masked_table();
		send_item(OP_REGISTER,   32'h1234_0000, 32'hFFFF_0000, 8'h21);
		send_item(OP_REGISTER,   32'h1234_5600, 32'hFFFF_FF00, 8'h22);
		send_item(OP_LOOKUP,     32'h1234_56AB, 32'h0000_0000, 8'h00);
		send_item(OP_LOOKUP,     32'h1234_FFFF, 32'h0000_0000, 8'h00);
		send_item(OP_REGISTER,   32'h1234_0000, 32'h0000_0000, 8'h33);
		send_item(OP_REGISTER,   32'h0000_0001, 32'h0000_0000, 8'h44);
		send_item(OP_LOOKUP,     32'h0000_0001, 32'h0000_0000, 8'h00);
		send_item(OP_DEREGISTER, 32'h1234_56FF, 32'hFFFF_FF00, 8'h00);
		send_item(OP_LOOKUP,     32'h1234_56AB, 32'h0000_0000, 8'h00);
	endtask

	// Catch-all entry, exact priority over it, reserved opcode, near-full mask.
	task automatic test_priority_and_odd_ops();
		send_item(OP_REGISTER,   32'h0000_0000, 32'h0000_0000, 8'h55);
		send_item(OP_LOOKUP,     32'hDEAD_BEEF, 32'h0000_0000, 8'h00);
		send_item(OP_LOOKUP,     32'h0000_0000, 32'h0000_0000, 8'h00);
		send_item(OP_RESERVED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_item(OP_DEREGISTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'hA5);
		send_item(OP_DEREGISTER, 32'h5A5A_5A5A, 32'h0000_0000, 8'h00);
	endtask

	// Random traffic in epochs: fill both tables past full, mix, then drain.
	task automatic test_random_traffic(input int n_items, input int idle_pct,
			input int stall_pct);
		epoch_e epoch;
		int roll;
		int idx;
		int lk_w;
		int rg_w;
		int dr_w;
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] msk;
		logic [HID_W-1:0] hid;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		// fresh pools per phase so that keys collide often, extremes included
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = $urandom;
		key_pool[0]  = 32'h0000_0000;
		key_pool[1]  = 32'hFFFF_FFFF;
		mask_pool[0] = 32'hFFFF_0000;
		mask_pool[1] = 32'hFFFF_FF00;
		mask_pool[2] = 32'hFF00_FF00;
		mask_pool[3] = 32'h0000_FFFF;
		mask_pool[4] = 32'h0000_0000;
		mask_pool[5] = 32'hFFFF_FFFE;
		mask_pool[6] = $urandom;
		mask_pool[7] = $urandom;
		for (int n = 0; n < n_items; n++) begin
			epoch = epoch_e'((n / EPOCH_LEN) % 3);
			case (epoch)
				FILL_EPOCH: begin
					lk_w = 25; rg_w = 95; dr_w = 98;
				end
				MIXED_EPOCH: begin
					lk_w = 45; rg_w = 70; dr_w = 95;
				end
				default: begin
					lk_w = 30; rg_w = 40; dr_w = 97;
				end
			endcase
			hid  = $urandom_range(255);
			roll = $urandom_range(99);
			if (roll < lk_w) begin
				op   = OP_LOOKUP;
				msk  = $urandom;
				roll = $urandom_range(99);
				idx  = pick_live_masked();
				if (roll < 45 && idx >= 0)
					key = mk_pat[idx] | ($urandom & ~mk_msk[idx]);
				else if (roll < 80)
					key = key_pool[$urandom_range(KEY_POOL - 1)];
				else
					key = $urandom;
			end else if (roll < rg_w) begin
				op  = OP_REGISTER;
				idx = $urandom_range(KEY_POOL - 1);
				if ($urandom_range(1)) begin
					msk = FULL_MASK;
					// while filling, prefer a key not yet stored so the table overflows
					if (epoch == FILL_EPOCH)
						for (int t = 0; t < KEY_POOL && exact_index(key_pool[idx]) >= 0; t++)
							idx = (idx + 1) % KEY_POOL;
					key = key_pool[idx];
				end else begin
					msk = mask_pool[$urandom_range(MASK_POOL - 1)];
					key = ($urandom_range(9) == 0) ? $urandom : (key_pool[idx] & msk);
				end
			end else if (roll < dr_w) begin
				op = OP_DEREGISTER;
				if ($urandom_range(99) < 80) begin
					if ($urandom_range(1)) begin
						idx = pick_live_exact();
						msk = FULL_MASK;
						key = (idx >= 0) ? ex_key[idx] : key_pool[$urandom_range(KEY_POOL - 1)];
					end else begin
						idx = pick_live_masked();
						if (idx >= 0) begin
							// own mask, or any mask covering the stored type
							msk = $urandom_range(1) ? mk_msk[idx] : (mk_pat[idx] | $urandom);
							key = mk_pat[idx] | ($urandom & ~msk);
						end else begin
							msk = mask_pool[$urandom_range(MASK_POOL - 1)];
							key = $urandom;
						end
					end
				end else begin
					msk = $urandom_range(1) ? FULL_MASK : mask_pool[$urandom_range(MASK_POOL - 1)];
					key = $urandom_range(1) ? $urandom : key_pool[$urandom_range(KEY_POOL - 1)];
				end
			end else begin
				op  = OP_RESERVED;
				key = $urandom;
				msk = $urandom;
			end
			send_item(op, key, msk, hid);
		end
	endtask

	initial begin
		for (int i = 0; i < EXACT_DEPTH; i++)
			ex_used[i] = 1'b0;
		for (int i = 0; i < MASKED_DEPTH; i++)
			mk_used[i] = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_exact_table();
		test_masked_table();
		test_priority_and_odd_ops();
		test_random_traffic(550, 19, 54);
		test_random_traffic(550, 54, 19);
		test_random_traffic(550, 0, 0);
		s_tvalid = 1'b0;

		// drain: every booked answer must arrive, then nothing more may follow
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
